FILE: rtl/pud_pkg.sv
// Shared constants, types and hex helpers for the percent unescape decoder.
package pud_pkg;

    localparam int UNIT_W     = 16;
    localparam int HOLD_DEPTH = 6;
    localparam int CNT_W      = 3;

    localparam logic [UNIT_W-1:0] UNIT_PERCENT = 16'h0025;
    localparam logic [UNIT_W-1:0] UNIT_LOWER_U = 16'h0075;

    localparam logic [CNT_W-1:0] LONG_FORM_LEN  = 3'd6;
    localparam logic [CNT_W-1:0] SHORT_FORM_LEN = 3'd3;

    // number of held units consumed by one decision
    localparam logic [CNT_W-1:0] DROP_ONE   = 3'd1;
    localparam logic [CNT_W-1:0] DROP_THREE = 3'd3;
    localparam logic [CNT_W-1:0] DROP_SIX   = 3'd6;

    // controller to datapath
    typedef struct packed {
        logic load;   // take the input item into the hold buffer
        logic step;   // carry out the current decision and emit its item
    } pud_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic emit;     // the head of the buffer is decided and yields an item
        logic done;     // nothing more can be decided for this item
        logic out_free; // the output register can take an item this cycle
    } pud_stat_t;

    function automatic logic hex_ok(input logic [UNIT_W-1:0] u);
        return (u >= 16'h0030 && u <= 16'h0039) ||
               (u >= 16'h0041 && u <= 16'h0046) ||
               (u >= 16'h0061 && u <= 16'h0066);
    endfunction

    // valid only where hex_ok holds
    function automatic logic [3:0] hex_val(input logic [UNIT_W-1:0] u);
        logic [3:0] v;
        if (u <= 16'h0039)
            v = u[3:0];
        else
            v = u[3:0] + 4'd9;
        return v;
    endfunction

endpackage

FILE: rtl/percent_unescape_decoder.sv
// Top level of the percent unescape decoder: controller plus datapath.
//
// Decodes a stream of 16-bit code units with percent escapes ("%XX" and
// "%uXXXX") into the unescaped stream.
// Input channel s_*: one code unit per item, s_tlast on the final unit of a
// string. Output channel m_*: one decoded unit per item, m_tlast on the final
// result of a string. A string's final input item flushes every held unit.
// Up to five units are held while an escape is still undecided; a failed
// escape emits '%' and rescans the units after it.
// Each item is taken in the idle state; the shared decode logic then makes
// one decision per cycle while the output register can take a result, and
// the item is closed once nothing more can be decided for it. The first
// result reaches m_tvalid through the controller state and the output register.
// Reset empties the hold buffer and the output register and leaves the block
// ready for input. A stall on m_tready holds the output item and the decision
// in progress; s_tready stays low until the item's last result has entered
// the output register.
module percent_unescape_decoder import pud_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,  // [15:0] code_unit
    input  logic        s_tlast,  // is_last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,  // [15:0] out_unit
    output logic        m_tlast   // out_last
);

    pud_cmd_t  cmd;
    pud_stat_t stat;

    // sequencing of accept and decision steps
    pud_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // hold buffer, decode and output register
    pud_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_unit   (s_tdata),
        .in_last   (s_tlast),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_unit  (m_tdata),
        .out_last  (m_tlast)
    );

endmodule

FILE: rtl/pud_ctrl.sv
// Controller state machine: accepts one item, then steps decisions until none is left.
module pud_ctrl import pud_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  pud_stat_t stat,
    output pud_cmd_t  cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SCAN = 1'b1;

    logic state_reg;
    logic state_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb
    begin
        cmd.load   = 1'b0;
        cmd.step   = 1'b0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                // hold while the output register is occupied
                if (stat.done)
                    state_next = ST_IDLE;
                else if (stat.emit && stat.out_free)
                    cmd.step = 1'b1;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

FILE: rtl/pud_datapath.sv
// Datapath: hold buffer, escape decision logic and output register.
module pud_datapath import pud_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [UNIT_W-1:0] in_unit,
    input  logic              in_last,
    input  pud_cmd_t          cmd,
    output pud_stat_t         stat,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [UNIT_W-1:0] out_unit,
    output logic              out_last
);

    logic [UNIT_W-1:0] held_reg  [HOLD_DEPTH];
    logic [UNIT_W-1:0] held_next [HOLD_DEPTH];
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    logic              last_reg;
    logic [UNIT_W-1:0] out_unit_reg;
    logic              out_last_reg;
    logic              out_valid_reg;

    logic [UNIT_W-1:0] emit_val;
    logic [CNT_W-1:0]  drop;
    logic [CNT_W-1:0]  cnt_after;
    logic              long_ok;
    logic              short_ok;
    logic              dec_emit;
    logic              dec_done;
    logic              slot_free;

    assign long_ok  = hex_ok(held_reg[2]) && hex_ok(held_reg[3]) &&
                      hex_ok(held_reg[4]) && hex_ok(held_reg[5]);
    assign short_ok = hex_ok(held_reg[1]) && hex_ok(held_reg[2]);

    // decide the head of the buffer; entries at or above the count are not looked at
    always_comb
    begin
        dec_emit = 1'b0;
        dec_done = 1'b0;
        emit_val = UNIT_PERCENT;
        drop     = DROP_ONE;
        if (cnt_reg == '0)
            dec_done = 1'b1;
        else if (held_reg[0] != UNIT_PERCENT)
        begin
            dec_emit = 1'b1;
            emit_val = held_reg[0];
        end
        else if (cnt_reg < 3'd2)
        begin
            dec_emit = last_reg;
            dec_done = !last_reg;
        end
        else if (held_reg[1] == UNIT_LOWER_U)
        begin
            if (cnt_reg < LONG_FORM_LEN)
            begin
                dec_emit = last_reg;
                dec_done = !last_reg;
            end
            else
            begin
                dec_emit = 1'b1;
                if (long_ok)
                begin
                    emit_val = {hex_val(held_reg[2]), hex_val(held_reg[3]),
                                hex_val(held_reg[4]), hex_val(held_reg[5])};
                    drop     = DROP_SIX;
                end
            end
        end
        else if (cnt_reg < SHORT_FORM_LEN)
        begin
            dec_emit = last_reg;
            dec_done = !last_reg;
        end
        else
        begin
            dec_emit = 1'b1;
            if (short_ok)
            begin
                emit_val = {8'h00, hex_val(held_reg[1]), hex_val(held_reg[2])};
                drop     = DROP_THREE;
            end
        end
    end

    assign cnt_after = cnt_reg - drop;
    assign slot_free = !out_valid_reg || out_ready;
    assign stat      = '{dec_emit, dec_done, slot_free};

    // append on load, shift out the consumed units on step
    always_comb
    begin
        held_next = held_reg;
        cnt_next  = cnt_reg;
        if (cmd.load)
        begin
            for (int i = 0; i < HOLD_DEPTH; i++)
            begin
                if (CNT_W'(i) == cnt_reg)
                    held_next[i] = in_unit;
            end
            cnt_next = cnt_reg + 3'd1;
        end
        else if (cmd.step)
        begin
            case (drop)
                DROP_ONE:
                begin
                    for (int i = 0; i < HOLD_DEPTH - 1; i++)
                        held_next[i] = held_reg[i + 1];
                end
                DROP_THREE:
                begin
                    for (int i = 0; i < HOLD_DEPTH - 3; i++)
                        held_next[i] = held_reg[i + 3];
                end
                DROP_SIX:
                begin
                    held_next = held_reg;
                end
                default:
                begin
                    held_next = held_reg;
                end
            endcase
            cnt_next = cnt_after;
        end
    end

    always_ff @(posedge clk)
    begin
        held_reg <= held_next;
        if (cmd.load)
            last_reg <= in_last;
        if (cmd.step)
        begin
            out_unit_reg <= emit_val;
            out_last_reg <= last_reg && (cnt_after == '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (cmd.step)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_unit  = out_unit_reg;
    assign out_last  = out_last_reg;

    a_load_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> (cnt_reg < LONG_FORM_LEN))
        else $error("item taken with a full hold buffer");

    a_step_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |-> (!out_valid_reg || out_ready))
        else $error("item emitted over an untaken output");

    a_last_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.step && last_reg && (cnt_after == '0)) |=> (cnt_reg == '0 && out_last_reg))
        else $error("final item of a string left units behind");

endmodule

FILE: bench/pud_checker.sv
// Checker for the percent unescape decoder: predicts decoded units and compares the output.
module pud_checker import pud_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,
    input  logic        m_tlast,
    output int          mismatches,
    output int          outstanding,
    output int          long_hits,
    output int          short_hits,
    output int          literal_pcts
);

    typedef struct packed {
        logic [UNIT_W-1:0] unit;
        logic              last;
    } decoded_t;

    logic [UNIT_W-1:0] held [HOLD_DEPTH];
    int                held_n;
    decoded_t          decoded_q[$];
    decoded_t          want;

    function automatic logic is_hex_digit(input logic [UNIT_W-1:0] u);
        return (u >= 16'h0030 && u <= 16'h0039) ||
               (u >= 16'h0041 && u <= 16'h0046) ||
               (u >= 16'h0061 && u <= 16'h0066);
    endfunction

    function automatic logic [3:0] nibble_of(input logic [UNIT_W-1:0] u);
        logic [UNIT_W-1:0] d;
        if (u <= 16'h0039)
            d = u - 16'h0030;
        else if (u <= 16'h0046)
            d = u - 16'h0037;
        else
            d = u - 16'h0057;
        return d[3:0];
    endfunction

    // Take one code unit into the hold buffer and decide as much as possible.
    task automatic decode_unit(input logic [UNIT_W-1:0] u, input logic fin);
        logic [UNIT_W-1:0] got [HOLD_DEPTH];
        logic [UNIT_W-1:0] v;
        logic              wait_more;
        decoded_t          d;
        int                n;
        int                drop;
        int                i;
        n = 0;
        wait_more = 1'b0;
        if (held_n < HOLD_DEPTH)
        begin
            held[held_n] = u;
            held_n++;
        end
        while (held_n > 0 && !wait_more)
        begin
            v = UNIT_PERCENT;
            drop = 1;
            if (held[0] != UNIT_PERCENT)
                v = held[0];
            else if (held_n < 2)
                wait_more = !fin;
            else if (held[1] == UNIT_LOWER_U)
            begin
                if (held_n < LONG_FORM_LEN)
                    wait_more = !fin;
                else if (is_hex_digit(held[2]) && is_hex_digit(held[3]) &&
                         is_hex_digit(held[4]) && is_hex_digit(held[5]))
                begin
                    v = {nibble_of(held[2]), nibble_of(held[3]),
                         nibble_of(held[4]), nibble_of(held[5])};
                    drop = LONG_FORM_LEN;
                end
            end
            else if (held_n < SHORT_FORM_LEN)
                wait_more = !fin;
            else if (is_hex_digit(held[1]) && is_hex_digit(held[2]))
            begin
                v = {8'h00, nibble_of(held[1]), nibble_of(held[2])};
                drop = SHORT_FORM_LEN;
            end
            if (!wait_more)
            begin
                if (drop == LONG_FORM_LEN)
                    long_hits++;
                else if (drop == SHORT_FORM_LEN)
                    short_hits++;
                else if (held[0] == UNIT_PERCENT)
                    literal_pcts++;
                if (n < HOLD_DEPTH)
                begin
                    got[n] = v;
                    n++;
                end
                for (i = 0; i + drop < held_n; i++)
                    held[i] = held[i + drop];
                held_n -= drop;
            end
        end
        for (i = 0; i < n; i++)
        begin
            d.unit = got[i];
            d.last = fin && (i == n - 1);
            decoded_q.insert(decoded_q.size(), d);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_n = 0;
            decoded_q.delete();
            mismatches = 0;
            long_hits = 0;
            short_hits = 0;
            literal_pcts = 0;
            outstanding <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                decode_unit(s_tdata, s_tlast);
            if (m_tvalid && m_tready)
            begin
                if (decoded_q.size() == 0)
                begin
                    $error("unexpected item: out_unit %h out_last %b", m_tdata, m_tlast);
                    mismatches++;
                end
                else
                begin
                    want = decoded_q.pop_front();
                    if (m_tdata !== want.unit)
                    begin
                        $error("out_unit: expected %h, actual %h", want.unit, m_tdata);
                        mismatches++;
                    end
                    if (m_tlast !== want.last)
                    begin
                        $error("out_last: expected %b, actual %b", want.last, m_tlast);
                        mismatches++;
                    end
                end
            end
            outstanding <= decoded_q.size();
        end
    end

endmodule

FILE: bench/tb_percent_unescape_decoder.sv
// Testbench top for the percent unescape decoder: stimulus, receiver, watchdog and verdict.
module tb_percent_unescape_decoder;
    import pud_pkg::*;

    // Roughly 30 directed items, then random strings until at least this many items in total.
    localparam int TOTAL_ITEMS     = 455;
    // Long receiver hold-off, in cycles, to fill the block and stall its input.
    localparam int HOLD_OFF_CYCLES = 300;
    // Cycles with no item moving on either side before the run is abandoned.
    localparam int QUIET_LIMIT     = 3000;
    // Settle time after the last expected item.
    localparam int DRAIN_CYCLES    = 24;

    logic        clk;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;   // [15:0] code_unit
    logic        s_tlast  = 1'b0; // is_last
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;         // [15:0] out_unit
    logic        m_tlast;         // out_last

    int mismatches;
    int outstanding;
    int long_hits;
    int short_hits;
    int literal_pcts;

    // Stimulus bookkeeping
    logic [15:0] str_q[$];        // units of the string being built
    int          sent      = 0;   // items accepted by the block
    int          str_count = 0;
    logic        calm      = 1'b0; // no idling on either side while set
    logic        stall_req = 1'b0; // raised by the sender, cleared by the receiver
    int          quiet     = 0;

    percent_unescape_decoder dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    pud_checker chk (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tlast      (s_tlast),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tlast      (m_tlast),
        .mismatches   (mismatches),
        .outstanding  (outstanding),
        .long_hits    (long_hits),
        .short_hits   (short_hits),
        .literal_pcts (literal_pcts)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Random hex digit, upper or lower case.
    function automatic logic [15:0] hex_char();
        int k;
        k = $urandom_range(21);
        if (k < 10)
            return 16'h0030 + 16'(k);
        else if (k < 16)
            return 16'h0041 + 16'(k - 10);
        else
            return 16'h0061 + 16'(k - 16);
    endfunction

    // Units at or just beside the hex ranges, plus the escape characters themselves
    // and look-alikes that differ only in the upper byte.
    function automatic logic [15:0] edge_char();
        case ($urandom_range(16))
            0:       return 16'h002F; // just below '0'
            1:       return 16'h003A; // just above '9'
            2:       return 16'h0040; // just below 'A'
            3:       return 16'h0047; // just above 'F'
            4:       return 16'h0060; // just below 'a'
            5:       return 16'h0067; // just above 'f'
            6:       return 16'h0030;
            7:       return 16'h0039;
            8:       return 16'h0041;
            9:       return 16'h0046;
            10:      return 16'h0061;
            11:      return 16'h0066;
            12:      return UNIT_LOWER_U;
            13:      return UNIT_PERCENT;
            14:      return 16'h0055; // upper-case 'U' is not the long form
            15:      return 16'h0125; // '%' in the low byte only
            default: return 16'h0130; // '0' in the low byte only
        endcase
    endfunction

    // Append one unit to the string being built.
    task automatic put_unit(input logic [15:0] u);
        str_q.insert(str_q.size(), u);
    endtask

    task automatic add_plain();
        case ($urandom_range(3))
            0, 1:    put_unit(16'($urandom_range(16'hFFFF)));
            2:       put_unit(16'($urandom_range(16'h007E, 16'h0020)));
            default: put_unit(edge_char());
        endcase
    endtask

    task automatic add_short();
        put_unit(UNIT_PERCENT);
        put_unit(hex_char());
        put_unit(hex_char());
    endtask

    task automatic add_long();
        put_unit(UNIT_PERCENT);
        put_unit(UNIT_LOWER_U);
        repeat (4) put_unit(hex_char());
    endtask

    // '%' with a cut-short or spoilt tail; some of these still decode by chance.
    task automatic add_broken();
        put_unit(UNIT_PERCENT);
        if ($urandom_range(1))
            put_unit(UNIT_LOWER_U);
        repeat ($urandom_range(3))
            put_unit(($urandom_range(9) < 7) ? hex_char() : edge_char());
    endtask

    // Offer one item, idling at random beforehand, and hold it until taken.
    task automatic send_unit(input logic [15:0] u, input logic fin);
        while (!calm && $urandom_range(99) < 33)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= u;
        s_tlast  <= fin;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sent++;
    endtask

    // Send the built string, flagging its final unit, and clear it.
    task automatic send_string();
        int i;
        for (i = 0; i < str_q.size(); i++)
            send_unit(str_q[i], i == str_q.size() - 1);
        str_q.delete();
        str_count++;
    endtask

    // Drop valid and hold until every predicted item has come out.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    // Receiver: random back-pressure, or a long hold-off when the sender asks.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (stall_req)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                stall_req = 1'b0;
            end
            else
                m_tready <= calm || ($urandom_range(99) >= 33);
        end
    end

    // Watchdog: abandon the run when nothing moves for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet <= 0;
        else if (quiet == QUIET_LIMIT)
        begin
            $display("percent_unescape_decoder: mismatch");
            $finish;
        end
        else
            quiet <= quiet + 1;
    end

    initial
    begin
        int   parts;
        logic stalled;
        logic paused;
        stalled = 1'b0;
        paused  = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed strings.
        // Two-digit form
        str_q = '{UNIT_PERCENT, 16'h0034, 16'h0031};
        send_string();
        // Long form, mixed case, largest value
        str_q = '{UNIT_PERCENT, UNIT_LOWER_U, 16'h0046, 16'h0066, 16'h0046, 16'h0066};
        send_string();
        // Long form with a bad digit: '%' out, then rescan from 'u'
        str_q = '{UNIT_PERCENT, UNIT_LOWER_U, 16'h0031, 16'h0032, 16'h0067, 16'h0034};
        send_string();
        // Long form cut short by the end of the string
        str_q = '{UNIT_PERCENT, UNIT_LOWER_U, 16'h0030};
        send_string();
        // Lone '%' at the end of the string
        str_q = '{UNIT_PERCENT};
        send_string();
        // Extremes of the code unit
        str_q = '{16'h0000, 16'hFFFF};
        send_string();
        // Failed '%' whose rescan starts a good escape
        str_q = '{UNIT_PERCENT, UNIT_PERCENT, 16'h0039, 16'h0061};
        send_string();
        // Smallest long-form value, then a trailing '%' with one unit after it
        str_q = '{UNIT_PERCENT, UNIT_LOWER_U, 16'h0030, 16'h0030, 16'h0030, 16'h0030,
                  UNIT_PERCENT, 16'h0041};
        send_string();

        // Random strings: a mix of well-formed escapes with random content,
        // plain units and broken escapes.
        while (sent < TOTAL_ITEMS)
        begin
            parts = $urandom_range(5, 1);
            repeat (parts)
            begin
                case ($urandom_range(9))
                    0, 1, 2: add_plain();
                    3, 4:    add_short();
                    5, 6:    add_long();
                    default: add_broken();
                endcase
            end

            // Pause once until everything predicted has arrived.
            if (!paused && sent >= 120)
            begin
                paused = 1'b1;
                drain();
            end
            // A stretch with no idling on either side.
            calm = (sent >= 180 && sent < 260);
            // Long receiver hold-off while the sender keeps offering.
            if (!stalled && sent >= 300)
            begin
                stalled = 1'b1;
                stall_req = 1'b1;
            end
            send_string();
        end

        // Wind down: wait for the last results, then let the block settle.
        drain();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d strings of %0d items: %0d four-digit and %0d two-digit escapes,",
                 str_count, sent, long_hits, short_hits);
        $display("  %0d '%%' units passed through undecoded", literal_pcts);
        if (mismatches == 0 && outstanding == 0)
            $display("percent_unescape_decoder: match");
        else
            $display("percent_unescape_decoder: mismatch");
        $finish;
    end

endmodule
